/* rtl/core/fsmf_pkg.sv */
`default_nettype none

package fsmf_pkg;

    // Longest pattern and offset range of the search
    localparam int unsigned PATTERN_MAX = 16;
    localparam int unsigned OFFSET_BITS = 16;

    // Output offset field and pattern length register widths
    localparam int unsigned MATCH_OFFSET_W = 16;
    localparam int unsigned LEN_W          = 5;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned WIN_IDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Width wide enough for the offset arithmetic and the output field
    localparam int unsigned SUM_W =
        (OFFSET_BITS + 1 > MATCH_OFFSET_W) ? OFFSET_BITS + 1 : MATCH_OFFSET_W;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH  = 2'd0,
        REG_PATTERN_WORD_LO = 2'd1,
        REG_PATTERN_WORD_HI = 2'd2
    } t_reg_index;

    // One classified text byte, front to back
    typedef struct packed {
        logic [7:0]             text_byte;
        logic                   last_byte;
        logic                   beyond;     // offset past the searchable range
        logic [OFFSET_BITS-1:0] offset;     // bytes of this text before this one
    } t_item;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

/* rtl/core/fsmf_front.sv */
`default_nettype none

module fsmf_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic [7:0]              i_text_byte,
    input  wire logic                    i_last_byte,
    output fsmf_pkg::t_item              o_item
);
    import fsmf_pkg::*;

    // Byte counter of the current text, saturates at the range limit
    logic [OFFSET_BITS:0] r_count;
    logic [OFFSET_BITS:0] n_count;
    logic                 w_beyond;

    assign w_beyond = r_count[OFFSET_BITS];

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            if (i_last_byte) begin
                n_count = '0;
            end else if (!w_beyond) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Classified beat for the queue
    always_comb begin
        o_item.text_byte = i_text_byte;
        o_item.last_byte = i_last_byte;
        o_item.beyond    = w_beyond;
        o_item.offset    = r_count[OFFSET_BITS-1:0];
    end

    // Counter holds at the limit, never past it
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_count[OFFSET_BITS] && (r_count[OFFSET_BITS-1:0] != '0)))
        else $error("front byte count past the range limit");

    // A marked last byte restarts the count
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_count == '0)
        else $error("byte count not cleared after last byte");

    // Saturated count stays saturated within a text
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_last_byte && w_beyond |=> r_count[OFFSET_BITS])
        else $error("byte count left saturation mid-text");

endmodule

`default_nettype wire

/* rtl/core/fsmf_queue.sv */
`default_nettype none

module fsmf_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire fsmf_pkg::t_item         i_item,
    input  wire logic                    i_pop,
    output fsmf_pkg::t_item              o_item,
    output fsmf_pkg::t_queue_status      o_status
);
    import fsmf_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from an empty queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level out of range");

endmodule

`default_nettype wire

/* rtl/core/fsmf_back.sv */
`default_nettype none

module fsmf_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [fsmf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [fsmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // queue head
    input  wire fsmf_pkg::t_item                    i_item,
    input  wire fsmf_pkg::t_queue_status            i_status,
    output logic                                    o_pop,
    // result beat
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_found,
    output logic [fsmf_pkg::MATCH_OFFSET_W-1:0]     o_match_offset,
    output logic                                    o_text_too_long
);
    import fsmf_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]      r_pattern_length;
    logic [CFG_DATA_W-1:0] r_pattern_word_lo;
    logic [CFG_DATA_W-1:0] r_pattern_word_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length  <= LEN_W'(1);
            r_pattern_word_lo <= '0;
            r_pattern_word_hi <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_PATTERN_LENGTH:  r_pattern_length  <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_WORD_LO: r_pattern_word_lo <= i_cfg_data;
                REG_PATTERN_WORD_HI: r_pattern_word_hi <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    // Effective length, clamped to the longest pattern
    logic [LEN_W-1:0] w_len;
    assign w_len = (r_pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : r_pattern_length;

    // Pattern bytes as an array
    logic [7:0] w_pat [PATTERN_MAX];
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < 8) begin
                w_pat[k] = r_pattern_word_lo[8*(k%8) +: 8];
            end else begin
                w_pat[k] = r_pattern_word_hi[8*(k%8) +: 8];
            end
        end
    end

    // Text state and window of recent bytes, newest at entry 0
    logic [7:0] r_win [PATTERN_MAX];
    logic       r_matched;
    logic       r_over;

    // Window as it stands once the head byte is shifted in
    logic [7:0] w_win [PATTERN_MAX];
    always_comb begin
        w_win[0] = i_item.text_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            w_win[j] = r_win[j-1];
        end
    end

    // Parallel compare: window entry j holds pattern byte len-1-j
    logic                 w_hit;
    logic [WIN_IDX_W-1:0] w_pidx [PATTERN_MAX];
    always_comb begin
        w_hit = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            w_pidx[j] = WIN_IDX_W'(w_len - LEN_W'(1) - LEN_W'(j));
            if ((LEN_W'(j) < w_len) && (w_pat[w_pidx[j]] != w_win[j])) begin
                w_hit = 1'b0;
            end
        end
    end

    // Decide what the head beat does
    logic             w_head;
    logic             w_search;
    logic [SUM_W-1:0] w_seen;
    logic [SUM_W-1:0] w_start;
    logic             w_match;
    logic             w_res;

    assign w_head   = !i_status.empty;
    assign w_search = !r_matched && !r_over && !i_item.beyond;
    assign w_seen   = SUM_W'(i_item.offset) + SUM_W'(1);
    assign w_start  = w_seen - SUM_W'(w_len);
    assign w_match  = w_search && (w_len != '0) && (w_seen >= SUM_W'(w_len)) && w_hit;
    assign w_res    = w_match || (i_item.last_byte && !r_matched);

    // Beats with no result never wait for the output register
    assign o_pop = w_head && (!w_res || !o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (o_pop && w_search) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= w_win[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= 1'b0;
            r_over    <= 1'b0;
        end else if (o_pop) begin
            if (i_item.last_byte) begin
                r_matched <= 1'b0;
                r_over    <= 1'b0;
            end else begin
                if (w_match) begin
                    r_matched <= 1'b1;
                end
                if (i_item.beyond && !r_matched) begin
                    r_over <= 1'b1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_pop && w_res) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res) begin
            o_found         <= w_match;
            o_match_offset  <= w_match ? w_start[MATCH_OFFSET_W-1:0] : '0;
            o_text_too_long <= !w_match && (r_over || i_item.beyond);
        end
    end

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> !o_text_too_long)
        else $error("found result flagged as too long");

    a_match_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && w_match && !i_item.last_byte |=> r_matched)
        else $error("match not remembered for the rest of the text");

    a_match_xor_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_matched && r_over))
        else $error("text both matched and overflowed");

endmodule

`default_nettype wire

/* rtl/core/first_substring_match_finder.sv */
`default_nettype none

// Leftmost substring search over a byte stream. Text bytes arrive one per
// beat on the slave side, tlast marking the final byte of a text. The block
// keeps a window of the last PATTERN_MAX bytes and compares it with the whole
// configured pattern in parallel, so it takes one byte per clock cycle while
// the queue has room. The byte that completes a result is stored in the queue,
// and the result is registered in the output register. As soon as a match
// completes, a beat with found set and the start offset is sent; the rest of
// that text yields nothing. A text that ends unmatched gives one beat with
// found clear, and text_too_long set if bytes went past the offset range.
// Pattern length zero never matches. Input bytes go through a two-entry queue,
// so a stalled result only holds back the input once that queue is full.
// Configuration must be written while no text is in flight.
module first_substring_match_finder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [fsmf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [fsmf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // text bytes
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // text_byte
    input  wire logic                                s_tlast,   // last_byte
    // results
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [fsmf_pkg::MATCH_OFFSET_W-1:0]      m_tdata,   // match_offset
    output logic [1:0]                               m_tuser    // text_too_long, found
);
    import fsmf_pkg::*;

    logic          w_accept;
    logic          w_pop;
    t_item         w_in_item;
    t_item         w_head_item;
    t_queue_status w_status;
    logic          w_found;
    logic          w_too_long;

    assign s_tready = !w_status.full;
    assign w_accept = s_tvalid && s_tready;

    fsmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_text_byte (s_tdata),
        .i_last_byte (s_tlast),
        .o_item      (w_in_item)
    );

    fsmf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_item   (w_in_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_status)
    );

    fsmf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_item          (w_head_item),
        .i_status        (w_status),
        .o_pop           (w_pop),
        .o_valid         (m_tvalid),
        .i_ready         (m_tready),
        .o_found         (w_found),
        .o_match_offset  (m_tdata),
        .o_text_too_long (w_too_long)
    );

    assign m_tuser = {w_too_long, w_found};

endmodule

`default_nettype wire
